FILE: rtl/lrupr_pkg.sv
`default_nettype none

package lrupr_pkg;

  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned CFG_W   = 4;
  localparam int unsigned LIM_W   = 5;
  localparam int unsigned FAULT_W = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  typedef struct packed {
    logic capture;
    logic match;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/lrupr_req_if.sv
`default_nettype none

interface lrupr_req_if #(
  parameter int unsigned PAGE_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page;

  modport source (output valid, output page, input ready);
  modport sink   (input valid, input page, output ready);
endinterface

`default_nettype wire

FILE: rtl/lrupr_rsp_if.sv
`default_nettype none

interface lrupr_rsp_if #(
  parameter int unsigned PAGE_BITS = 16
);
  logic                               valid;
  logic                               ready;
  logic                               hit;
  logic [lrupr_pkg::SLOT_W-1:0]       slot;
  logic                               evicted_valid;
  logic [PAGE_BITS-1:0]               evicted_page;
  logic [lrupr_pkg::FAULT_W-1:0]      fault_count;

  modport source (output valid, output hit, output slot, output evicted_valid,
                  output evicted_page, output fault_count, input ready);
  modport sink   (input valid, input hit, input slot, input evicted_valid,
                  input evicted_page, input fault_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/lru_page_replacement.sv
// Each request runs through capture, lookup and commit; its response becomes
// valid at commit, which waits while the previous response is held.
// The controller's single-request sequence takes no new request until commit.
// Reset: asynchronous, active low; clears frame valid bits, ages, the fault
// count and the frame limit (to 8). Frame pages are written on every miss.
`default_nettype none

module lru_page_replacement #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  lrupr_req_if.sink                        req_i,
  lrupr_rsp_if.source                      rsp_o,
  input  wire logic                        frames_in_use_we_i,
  input  wire logic [lrupr_pkg::CFG_W-1:0] frames_in_use_i
);

  lrupr_pkg::cmd_t    cmd;
  lrupr_pkg::status_t sts;

  lrupr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lrupr_dpath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (frames_in_use_we_i),
    .cfg_i           (frames_in_use_i),
    .req_page_i      (req_i.page),
    .rsp_ready_i     (rsp_o.ready),
    .rsp_valid_o     (rsp_o.valid),
    .hit_o           (rsp_o.hit),
    .slot_o          (rsp_o.slot),
    .evicted_valid_o (rsp_o.evicted_valid),
    .evicted_page_o  (rsp_o.evicted_page),
    .fault_count_o   (rsp_o.fault_count)
  );

`ifndef SYNTHESIS
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.hit |-> !rsp_o.evicted_valid && (rsp_o.evicted_page == '0))
    else $error("hit response reports an eviction");

  a_fault_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) && !rsp_o.hit |-> (rsp_o.fault_count != '0))
    else $error("fault response with zero fault count");

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request taken while another is in flight");
`endif

endmodule

`default_nettype wire

FILE: rtl/lrupr_ctrl.sv
`default_nettype none

module lrupr_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               req_valid_i,
  output logic                    req_ready_o,
  output lrupr_pkg::cmd_t         cmd_o,
  input  wire lrupr_pkg::status_t sts_i
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MATCH  = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd_o.match = 1'b1;
        state_d     = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the result register can take the response
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lrupr_dpath.sv
`default_nettype none

module lrupr_dpath #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire lrupr_pkg::cmd_t                 cmd_i,
  output lrupr_pkg::status_t                   sts_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [lrupr_pkg::CFG_W-1:0]     cfg_i,
  input  wire logic [PAGE_BITS-1:0]            req_page_i,
  input  wire logic                            rsp_ready_i,
  output logic                                 rsp_valid_o,
  output logic                                 hit_o,
  output logic [lrupr_pkg::SLOT_W-1:0]         slot_o,
  output logic                                 evicted_valid_o,
  output logic [PAGE_BITS-1:0]                 evicted_page_o,
  output logic [lrupr_pkg::FAULT_W-1:0]        fault_count_o
);

  localparam int unsigned IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [IW-1:0] RANK_TOP = IW'(FRAMES - 1);
  localparam logic [IW:0]   AGE_ALL  = (IW + 1)'(FRAMES);
  localparam logic [lrupr_pkg::LIM_W-1:0] LIM_MAX = lrupr_pkg::LIM_W'(FRAMES);

  logic [lrupr_pkg::CFG_W-1:0]   cfg_q;
  logic [PAGE_BITS-1:0]          page_q;
  logic [PAGE_BITS-1:0]          frame_page_q [FRAMES];
  logic [FRAMES-1:0]             valid_q;
  logic [IW-1:0]                 rank_q [FRAMES];
  logic [lrupr_pkg::FAULT_W-1:0] faults_q;

  logic [IW-1:0] sel_q;
  logic          hit_q;
  logic          evict_q;
  logic [IW:0]   old_age_q;

  logic                          rsp_valid_q;
  logic                          rsp_hit_q;
  logic [lrupr_pkg::SLOT_W-1:0]  rsp_slot_q;
  logic                          rsp_ev_valid_q;
  logic [PAGE_BITS-1:0]          rsp_ev_page_q;

  logic [lrupr_pkg::LIM_W-1:0] lim;
  logic [FRAMES-1:0]           in_lim;
  logic [FRAMES-1:0]           hit_vec;
  logic [FRAMES-1:0]           free_vec;
  logic [FRAMES-1:0]           max_vec;
  logic [IW-1:0]               hit_idx, free_idx, max_idx;
  logic [IW-1:0]               sel_d;
  logic [IW:0]                 old_age_d;
  logic [lrupr_pkg::FAULT_W-1:0] faults_d;

  always_comb begin
    priority if (cfg_q == '0) begin
      lim = lrupr_pkg::LIM_W'(1);
    end else if (lrupr_pkg::LIM_W'(cfg_q) > LIM_MAX) begin
      lim = LIM_MAX;
    end else begin
      lim = lrupr_pkg::LIM_W'(cfg_q);
    end
  end

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      in_lim[i]   = lrupr_pkg::LIM_W'(i) < lim;
      hit_vec[i]  = in_lim[i] && valid_q[i] && (frame_page_q[i] == page_q);
      free_vec[i] = in_lim[i] && !valid_q[i];
    end
  end

  // oldest frame: strictly older than lower frames, no younger than higher ones
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      max_vec[i] = in_lim[i];
      for (int j = 0; j < FRAMES; j++) begin
        if (in_lim[j] && (j != i)) begin
          if (j < i) begin
            if (rank_q[i] <= rank_q[j]) max_vec[i] = 1'b0;
          end else begin
            if (rank_q[i] < rank_q[j]) max_vec[i] = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    max_idx  = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (hit_vec[i])  hit_idx  = IW'(i);
      if (free_vec[i]) free_idx = IW'(i);
      if (max_vec[i])  max_idx  = IW'(i);
    end
  end

  always_comb begin
    priority if (|hit_vec) begin
      sel_d     = hit_idx;
      old_age_d = {1'b0, rank_q[hit_idx]};
    end else if (|free_vec) begin
      sel_d     = free_idx;
      old_age_d = AGE_ALL;
    end else begin
      sel_d     = max_idx;
      old_age_d = {1'b0, rank_q[max_idx]};
    end
  end

  assign faults_d = (faults_q == '1) ? faults_q : faults_q + 1'b1;

  assign sts_o.out_busy = rsp_valid_q && !rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= lrupr_pkg::CFG_RESET;
      valid_q     <= '0;
      faults_q    <= '0;
      rsp_valid_q <= 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) cfg_q <= cfg_i;
      if (rsp_valid_q && rsp_ready_i) rsp_valid_q <= 1'b0;
      if (cmd_i.commit) begin
        rsp_valid_q <= 1'b1;
        if (!hit_q) begin
          valid_q[sel_q] <= 1'b1;
          faults_q       <= faults_d;
        end
        for (int i = 0; i < FRAMES; i++) begin
          if (IW'(i) == sel_q) begin
            rank_q[i] <= '0;
          end else if (in_lim[i] && valid_q[i] && ({1'b0, rank_q[i]} < old_age_q) &&
                       (rank_q[i] < RANK_TOP)) begin
            rank_q[i] <= rank_q[i] + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) page_q <= req_page_i;
    if (cmd_i.match) begin
      sel_q     <= sel_d;
      hit_q     <= |hit_vec;
      evict_q   <= !(|hit_vec) && !(|free_vec);
      old_age_q <= old_age_d;
    end
    if (cmd_i.commit) begin
      if (!hit_q) frame_page_q[sel_q] <= page_q;
      rsp_hit_q      <= hit_q;
      rsp_slot_q     <= lrupr_pkg::SLOT_W'(sel_q);
      rsp_ev_valid_q <= evict_q;
      rsp_ev_page_q  <= evict_q ? frame_page_q[sel_q] : '0;
    end
  end

  assign rsp_valid_o     = rsp_valid_q;
  assign hit_o           = rsp_hit_q;
  assign slot_o          = rsp_slot_q;
  assign evicted_valid_o = rsp_ev_valid_q;
  assign evicted_page_o  = rsp_ev_page_q;
  assign fault_count_o   = faults_q;

endmodule

`default_nettype wire
